/* hdl/dvrt_pkg.sv */
// Package for the distance-vector route table: payload structs, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dvrt_pkg;

  localparam logic [4:0] CostInf = 5'd16;

  typedef enum logic [2:0] {
    MODE_CONNECT = 3'd0,
    MODE_ROUTE   = 3'd1,
    MODE_EOM     = 3'd2,
    MODE_TICK    = 3'd3,
    MODE_ADV     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_ENTRY = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_RUN  = 2'd1,
    FSM_OUT  = 2'd2
  } fsm_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] peer_addr;
    logic [31:0] dest_addr;
    logic [4:0]  metric;
  } dvrt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] route_dest;
    logic [4:0]  route_cost;
    logic        last;
  } dvrt_out_t;

  // One table entry
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] hop;
    logic [4:0]  cost;
    logic [7:0]  exp_t;
    logic [7:0]  gc_t;
  } entry_t;

  // Command struct for the cells (not used by dvrt_cell or the table)
  typedef struct packed {
    logic        rotate;   // shift ring one step (entry 0 leaves, new enters at tail)
    logic [2:0]  mode;
    logic [31:0] peer;
    logic [4:0]  cost;
    logic [7:0]  exp_lim;
    logic [7:0]  gc_lim;
  } cell_cmd_t;

endpackage
`default_nettype wire

/* hdl/dvrt_cell.sv */
// One entry register of the route table ring.
// Depends on dvrt_pkg. Loads from its neighbor, or takes the updated head entry at the tail.
`timescale 1ns / 1ps
`default_nettype none
module dvrt_cell import dvrt_pkg::*; (
  input  wire        clk_i,
  input  wire        load_i,
  input  entry_t     d_i,
  output entry_t     q_o
);
  entry_t e_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      e_q <= d_i;
    end
  end

  assign q_o = e_q;
endmodule
`default_nettype wire

/* hdl/distance_vector_route_table.sv */
// Distance-vector route table (RIP style) built as a ring of entry cells.
// Each item rotates the ring once, one item at a time; mode 4 delivers one
// result per listed entry as the ring turns.
// A new item is taken only once the pass over the ring is over and the
// last result has been taken; output stalls hold it off longer.
// Reset (async, active low) empties the table and loads both limits with 30.
// Depends on dvrt_pkg and dvrt_cell.
`timescale 1ns / 1ps
`default_nettype none
module distance_vector_route_table import dvrt_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  dvrt_in_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output dvrt_out_t  out_data_o,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire  [2:0] paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);

  // Configuration registers
  logic [7:0] exp_lim_q, gc_lim_q;
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_lim_q <= 8'd30;
      gc_lim_q  <= 8'd30;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'b0) exp_lim_q <= pwdata[7:0];
      else                  gc_lim_q  <= pwdata[7:0];
    end
  end
  assign prdata = {24'd0, paddr[2] ? gc_lim_q : exp_lim_q};

  // Ring of cells: entries [0..count-1] valid; rotate moves head to tail.
  entry_t cell_q [TABLE_DEPTH];
  entry_t cell_d [TABLE_DEPTH];
  logic   shift;
  logic   app;                // append one entry at tail_idx, no rotation
  logic [CW-1:0] tail_idx;   // where the returning head entry lands
  entry_t tail_d;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic ld;
      if (g == TABLE_DEPTH - 1) begin : g_tail
        assign cell_d[g] = tail_d;
      end else begin : g_body
        assign cell_d[g] = (CW'(g) == tail_idx) ? tail_d : cell_q[g+1];
      end
      assign ld = (shift && (CW'(g) <= tail_idx || g == TABLE_DEPTH - 1)) ||
                  (app && CW'(g) == tail_idx);
      dvrt_cell u_cell (
        .clk_i (clk_i),
        .load_i(ld),
        .d_i   (cell_d[g]),
        .q_o   (cell_q[g])
      );
    end
  endgenerate

  // Control
  fsm_e          st_q, st_d;
  dvrt_in_t      cmd_q;
  logic [4:0]    cost_q;
  logic [CW-1:0] cnt_q, cnt_d;     // entries in table
  logic [CW-1:0] left_q, left_d;   // entries still to visit
  logic          found_q, found_d; // mode 1 matched / mode 4 emitted
  logic          ov_q, ov_d;
  dvrt_out_t     od_q, od_d;
  logic          accept, out_take;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = ov_q && !out_stall_i;
  assign in_stall_o = (st_q != FSM_IDLE) || ov_q;

  entry_t head, upd;
  logic   drop;
  logic   emit;
  logic [5:0] mplus;

  always_comb begin
    head = cell_q[0];
    upd  = head;
    drop = 1'b0;
    emit = 1'b0;
    case (cmd_q.mode)
      MODE_ROUTE: begin
        if (!found_q && head.dest == cmd_q.dest_addr) begin
          if (head.hop != cmd_q.peer_addr) begin
            if (cost_q < head.cost) begin
              upd.cost = cost_q;
              upd.hop  = cmd_q.peer_addr;
            end
          end else begin
            upd.cost = cost_q;
          end
        end
      end
      MODE_EOM: begin
        if ((head.hop == cmd_q.peer_addr || head.dest == cmd_q.peer_addr)
            && head.cost < CostInf) begin
          upd.exp_t = 8'd0;
          upd.gc_t  = 8'd0;
        end
      end
      MODE_TICK: begin
        if (head.gc_t >= gc_lim_q) drop = 1'b1;
        else if (head.exp_t >= exp_lim_q) begin
          upd.cost = CostInf;
          if (head.gc_t != 8'hFF) upd.gc_t = head.gc_t + 8'd1;
        end else begin
          upd.exp_t = head.exp_t + 8'd1;
        end
      end
      MODE_ADV: emit = (head.hop != cmd_q.peer_addr);
      default: ;
    endcase
  end

  assign mplus = {1'b0, in_data_i.metric} + 6'd1;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    found_d = found_q;
    ov_d    = ov_q && !out_take;
    od_d    = od_q;
    shift   = 1'b0;
    app     = 1'b0;
    tail_idx = cnt_q - CW'(1);
    tail_d  = upd;
    case (st_q)
      FSM_IDLE: begin
        if (accept) begin
          st_d = FSM_RUN; left_d = cnt_q; found_d = 1'b0;
        end
      end
      FSM_RUN: begin
        if (left_q != '0) begin
          // mode 4 waits while an earlier listed entry is still held
          if (!(cmd_q.mode == MODE_ADV && emit && ov_q && out_stall_i)) begin
            shift = 1'b1;
            left_d = left_q - CW'(1);
            if (cmd_q.mode == MODE_ROUTE && head.dest == cmd_q.dest_addr)
              found_d = 1'b1;
            if (drop) begin
              tail_idx = Full; // nothing lands; entries slide up
              cnt_d = cnt_q - CW'(1);
            end
            if (emit) begin
              // emit now with last=0; the pending stage below holds each result
              // so that last can be set on the final listed entry on completion
              ov_d = 1'b1;
              od_d = '{status: ST_ENTRY, route_dest: head.dest,
                       route_cost: head.cost, last: 1'b0};
              found_d = 1'b1;
            end
          end
        end else if (!(ov_q && out_stall_i)) begin
          st_d = FSM_OUT;
        end
      end
      FSM_OUT: begin
        if (!ov_q || out_take) begin
          st_d = FSM_IDLE;
          ov_d = 1'b1;
          od_d = '{status: ST_DONE, route_dest: 32'd0, route_cost: 5'd0,
                   last: 1'b1};
          case (cmd_q.mode)
            MODE_CONNECT, MODE_ROUTE: begin
              if (cmd_q.mode == MODE_ROUTE && found_q) begin
              end else if (cnt_q == Full) begin
                od_d.status = ST_FULL;
              end else begin
                app      = 1'b1;
                tail_idx = cnt_q;
                tail_d   = '{dest: cmd_q.dest_addr,
                             hop: (cmd_q.mode == MODE_ROUTE) ? cmd_q.peer_addr : 32'd0,
                             cost: (cmd_q.mode == MODE_ROUTE) ? cost_q : 5'd1,
                             exp_t: 8'd0, gc_t: 8'd0};
                cnt_d = cnt_q + CW'(1);
              end
            end
            MODE_ADV: if (!found_q) od_d.status = ST_NONE;
            default: ;
          endcase
        end
      end
      default: st_d = FSM_IDLE;
    endcase
  end

  // mode 4 last flag: a listed entry is held until the next one comes so last
  // can be set on it; implemented by a pending stage below.
  dvrt_out_t pend_q;
  logic      pv_q;
  logic      pend_in, last_fix;
  assign pend_in  = (od_d.status == ST_ENTRY) && ov_d && !(ov_q && !out_take)
                    && st_q == FSM_RUN;
  assign last_fix = (st_q == FSM_OUT) && (cmd_q.mode == MODE_ADV) && found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FSM_IDLE; cnt_q <= '0; left_q <= '0;
      found_q <= 1'b0; ov_q <= 1'b0; pv_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; left_q <= left_d;
      found_q <= found_d;
      // listed entries go to pending; previous pending goes out
      if (pend_in) begin
        pv_q <= 1'b1;
        ov_q <= pv_q;
      end else if (last_fix && (!ov_q || out_take)) begin
        pv_q <= 1'b0;
        ov_q <= 1'b1;
      end else begin
        ov_q <= ov_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_data_i;
      cost_q <= mplus > 6'd16 ? CostInf : mplus[4:0];
    end
    if (pend_in) begin
      pend_q <= od_d;
      if (pv_q) od_q <= pend_q;
    end else if (last_fix && (!ov_q || out_take)) begin
      od_q <= '{status: ST_ENTRY, route_dest: pend_q.route_dest,
                route_cost: pend_q.route_cost, last: 1'b1};
    end else begin
      od_q <= od_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  logic unused;
  assign unused = ^{pwdata[31:8], paddr[1:0]};
endmodule
`default_nettype wire
